// ===== rtl/one_wire_bus_master_top_defines.svh =====
// Assertion helpers used by the checker file of the bus master.
`ifndef ONE_WIRE_BUS_MASTER_TOP_DEFINES_SVH
`define ONE_WIRE_BUS_MASTER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define OW_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("one-wire master: same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define OW_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("one-wire master: next-cycle check failed");

`endif

// ===== rtl/ow_pkg.sv =====
package ow_pkg;

  localparam int DATA_BITS = 8;
  localparam int BIT_AW    = $clog2(DATA_BITS);
  localparam int CNT_W     = 10;
  localparam int BIDX_W    = 4;
  localparam int CFG_IW    = 3;
  localparam int CFG_DW    = 10;
  localparam int Q_DEPTH   = 2;
  localparam int Q_AW      = $clog2(Q_DEPTH);
  localparam int Q_CW      = $clog2(Q_DEPTH + 1);

  localparam logic [CNT_W-1:0]  CNT_MAX    = '1;
  localparam logic [BIDX_W-1:0] BYTE_TOTAL = BIDX_W'(DATA_BITS);
  localparam logic [BIDX_W-1:0] BIT_TOTAL  = BIDX_W'(1);

  // Configuration register indexes.
  localparam logic [CFG_IW-1:0] REG_RESET_LOW     = 3'd0;
  localparam logic [CFG_IW-1:0] REG_PRESENCE_WAIT = 3'd1;
  localparam logic [CFG_IW-1:0] REG_RESET_TAIL    = 3'd2;
  localparam logic [CFG_IW-1:0] REG_WRITE_ONE_LOW = 3'd3;
  localparam logic [CFG_IW-1:0] REG_WRITE_SLOT    = 3'd4;
  localparam logic [CFG_IW-1:0] REG_READ_LOW      = 3'd5;
  localparam logic [CFG_IW-1:0] REG_READ_SAMPLE   = 3'd6;
  localparam logic [CFG_IW-1:0] REG_READ_TAIL     = 3'd7;

  typedef enum logic [2:0] {
    K_TICK  = 3'd0,
    K_RESET = 3'd1,
    K_WBYTE = 3'd2,
    K_RBYTE = 3'd3,
    K_WBIT  = 3'd4,
    K_RBIT  = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    CL_TICK = 3'b001,
    CL_CMD  = 3'b010,
    CL_NOP  = 3'b100
  } class_t;

  typedef enum logic [9:0] {
    PH_IDLE     = 10'b00_0000_0001,
    PH_RST_LOW  = 10'b00_0000_0010,
    PH_RST_WAIT = 10'b00_0000_0100,
    PH_RST_TAIL = 10'b00_0000_1000,
    PH_W1_LOW   = 10'b00_0001_0000,
    PH_W1_REL   = 10'b00_0010_0000,
    PH_W0_HOLD  = 10'b00_0100_0000,
    PH_RD_LOW   = 10'b00_1000_0000,
    PH_RD_WAIT  = 10'b01_0000_0000,
    PH_RD_TAIL  = 10'b10_0000_0000
  } phase_t;

  typedef struct packed {
    logic [9:0] reset_low_us;
    logic [7:0] presence_wait_us;
    logic [9:0] reset_tail_us;
    logic [3:0] write_one_low_us;
    logic [7:0] write_slot_us;
    logic [3:0] read_low_us;
    logic [5:0] read_sample_us;
    logic [7:0] read_tail_us;
  } cfg_t;

  typedef struct packed {
    class_t                 cls;
    kind_t                  kind;
    logic [DATA_BITS-1:0]   data;
    logic                   line;
  } item_t;

  typedef struct packed {
    phase_t                 phase;
    logic [CNT_W-1:0]       cnt;
    logic [BIDX_W-1:0]      bidx;
    logic [DATA_BITS-1:0]   sreg;
    kind_t                  opk;
  } seq_t;

  typedef struct packed {
    logic                   drive_low;
    logic                   busy;
    logic                   done;
    logic [DATA_BITS-1:0]   data;
    logic                   rejected;
  } res_t;

endpackage

// ===== rtl/one_wire_bus_master_top.sv =====
// Channel   Direction  Handshake            Beat contents
// input     in         in_valid / in_stall  kind, data, line_level
// output    out        out_valid / out_stall drive_low, busy_res, done_res,
//                                           result_data, rejected
// config    in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// A tick or command beat normally leaves the sequencer in one step, so
// beats flow back to back while the result channel is free; each further phase
// of zero length adds a step, as the sequencer makes one phase step a cycle.
// Reset is synchronous and active high; it loads the default slot timings and
// returns the sequencer to idle. A two-beat queue sits between the input and
// the sequencer, and the result register frees as its beat is taken, so a stall
// on either side holds only that side until the queue fills.
module one_wire_bus_master_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [2:0]                    kind,
  input  logic [ow_pkg::DATA_BITS-1:0]  data,
  input  logic                          line_level,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          drive_low,
  output logic                          busy_res,
  output logic                          done_res,
  output logic [ow_pkg::DATA_BITS-1:0]  result_data,
  output logic                          rejected,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ow_pkg::CFG_IW-1:0]     cfg_index,
  input  logic [ow_pkg::CFG_DW-1:0]     cfg_data
);

  ow_pkg::cfg_t   cfg;
  ow_pkg::item_t  push_item;
  ow_pkg::item_t  head;
  ow_pkg::res_t   res;
  logic           push;
  logic           q_full;
  logic           q_valid;
  logic           pop;

  // Host must write timing registers only while the bus is quiet; not enforced.
  ow_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // The front end classifies each beat as a tick, a command or a no-op.
  ow_front u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .kind       (kind),
    .data       (data),
    .line_level (line_level),
    .q_full     (q_full),
    .push       (push),
    .push_item  (push_item)
  );

  // The queue lets the front keep taking beats while a result waits.
  ow_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .head      (head)
  );

  // The back end runs the slot sequencer and owns the result register. A beat
  // leaves the queue only once its result is written, as the sampled line level
  // is read from the queue head for as long as the beat is being worked on.
  ow_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res       (res)
  );

  assign drive_low   = res.drive_low;
  assign busy_res    = res.busy;
  assign done_res    = res.done;
  assign result_data = res.data;
  assign rejected    = res.rejected;

endmodule

// ===== rtl/ow_cfg.sv =====
module ow_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [ow_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [ow_pkg::CFG_DW-1:0]   cfg_data,
  output ow_pkg::cfg_t                cfg
);

  assign cfg_ready = 1'b1;

  // Each register keeps only as many low bits of the written word as it has.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reset_low_us     <= 10'd490;
      cfg.presence_wait_us <= 8'd40;
      cfg.reset_tail_us    <= 10'd450;
      cfg.write_one_low_us <= 4'd1;
      cfg.write_slot_us    <= 8'd100;
      cfg.read_low_us      <= 4'd1;
      cfg.read_sample_us   <= 6'd15;
      cfg.read_tail_us     <= 8'd105;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ow_pkg::REG_RESET_LOW:     cfg.reset_low_us     <= cfg_data[9:0];
        ow_pkg::REG_PRESENCE_WAIT: cfg.presence_wait_us <= cfg_data[7:0];
        ow_pkg::REG_RESET_TAIL:    cfg.reset_tail_us    <= cfg_data[9:0];
        ow_pkg::REG_WRITE_ONE_LOW: cfg.write_one_low_us <= cfg_data[3:0];
        ow_pkg::REG_WRITE_SLOT:    cfg.write_slot_us    <= cfg_data[7:0];
        ow_pkg::REG_READ_LOW:      cfg.read_low_us      <= cfg_data[3:0];
        ow_pkg::REG_READ_SAMPLE:   cfg.read_sample_us   <= cfg_data[5:0];
        ow_pkg::REG_READ_TAIL:     cfg.read_tail_us     <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== rtl/ow_front.sv =====
module ow_front (
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [2:0]                    kind,
  input  logic [ow_pkg::DATA_BITS-1:0]  data,
  input  logic                          line_level,
  input  logic                          q_full,
  output logic                          push,
  output ow_pkg::item_t                 push_item
);

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  // Sort each beat into a tick, a command, or a code with no meaning.
  always_comb begin
    push_item.kind = ow_pkg::kind_t'(kind);
    push_item.data = data;
    push_item.line = line_level;
    case (kind)
      ow_pkg::K_TICK:  push_item.cls = ow_pkg::CL_TICK;
      ow_pkg::K_RESET,
      ow_pkg::K_WBYTE,
      ow_pkg::K_RBYTE,
      ow_pkg::K_WBIT,
      ow_pkg::K_RBIT:  push_item.cls = ow_pkg::CL_CMD;
      default:         push_item.cls = ow_pkg::CL_NOP;
    endcase
  end

endmodule

// ===== rtl/ow_queue.sv =====
module ow_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ow_pkg::item_t  push_item,
  output logic           full,
  input  logic           pop,
  output logic           q_valid,
  output ow_pkg::item_t  head
);

  ow_pkg::item_t                 mem [ow_pkg::Q_DEPTH];
  logic [ow_pkg::Q_AW-1:0]       wptr;
  logic [ow_pkg::Q_AW-1:0]       rptr;
  logic [ow_pkg::Q_CW-1:0]       count;

  localparam logic [ow_pkg::Q_AW-1:0] LAST = ow_pkg::Q_AW'(ow_pkg::Q_DEPTH - 1);

  assign full    = (count == ow_pkg::Q_CW'(ow_pkg::Q_DEPTH));
  assign q_valid = (count != '0);
  assign head    = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == LAST) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == LAST) ? '0 : rptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/ow_back.sv =====
module ow_back (
  input  logic           clk,
  input  logic           rst,
  input  ow_pkg::cfg_t   cfg,
  input  logic           q_valid,
  input  ow_pkg::item_t  head,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_stall,
  output ow_pkg::res_t   res
);

  ow_pkg::seq_t                   cur;
  ow_pkg::seq_t                   ent;
  ow_pkg::seq_t                   adv;
  ow_pkg::seq_t                   nxt;
  logic                           working;
  logic                           go;
  logic                           cont;
  logic                           more;
  logic                           rej;
  logic                           fin;
  logic [ow_pkg::DATA_BITS-1:0]   fin_data;
  logic [ow_pkg::BIDX_W-1:0]      nb;
  logic [ow_pkg::BIDX_W-1:0]      total;
  logic                           is_write;

  function automatic logic [ow_pkg::CNT_W-1:0] phase_dur(input ow_pkg::phase_t p,
                                                         input ow_pkg::cfg_t c);
    logic [ow_pkg::CNT_W-1:0] d;
    case (p)
      ow_pkg::PH_RST_LOW:  d = c.reset_low_us;
      ow_pkg::PH_RST_WAIT: d = ow_pkg::CNT_W'(c.presence_wait_us);
      ow_pkg::PH_RST_TAIL: d = c.reset_tail_us;
      ow_pkg::PH_W1_LOW:   d = ow_pkg::CNT_W'(c.write_one_low_us);
      ow_pkg::PH_W1_REL,
      ow_pkg::PH_W0_HOLD:  d = ow_pkg::CNT_W'(c.write_slot_us);
      ow_pkg::PH_RD_LOW:   d = ow_pkg::CNT_W'(c.read_low_us);
      ow_pkg::PH_RD_WAIT:  d = ow_pkg::CNT_W'(c.read_sample_us);
      ow_pkg::PH_RD_TAIL:  d = ow_pkg::CNT_W'(c.read_tail_us);
      default:             d = '0;
    endcase
    return d;
  endfunction

  assign go  = q_valid && (!out_valid || !out_stall);
  assign pop = go && !more;

  // Entry: the head beat's own effect, applied once per beat.
  always_comb begin
    ent = cur;
    rej = 1'b0;
    if (!working) begin
      case (head.cls)
        ow_pkg::CL_TICK: begin
          if (cur.phase != ow_pkg::PH_IDLE && cur.cnt != ow_pkg::CNT_MAX) begin
            ent.cnt = cur.cnt + 1'b1;
          end
        end
        ow_pkg::CL_CMD: begin
          if (cur.phase != ow_pkg::PH_IDLE) begin
            rej = 1'b1;
          end else begin
            ent.opk  = head.kind;
            ent.bidx = '0;
            ent.cnt  = '0;
            case (head.kind)
              ow_pkg::K_RESET: begin
                ent.sreg  = '0;
                ent.phase = ow_pkg::PH_RST_LOW;
              end
              ow_pkg::K_WBYTE: begin
                ent.sreg  = head.data;
                ent.phase = head.data[0] ? ow_pkg::PH_W1_LOW : ow_pkg::PH_W0_HOLD;
              end
              ow_pkg::K_WBIT: begin
                ent.sreg  = ow_pkg::DATA_BITS'(head.data[0]);
                ent.phase = head.data[0] ? ow_pkg::PH_W1_LOW : ow_pkg::PH_W0_HOLD;
              end
              default: begin
                ent.sreg  = '0;
                ent.phase = ow_pkg::PH_RD_LOW;
              end
            endcase
          end
        end
        default: begin
        end
      endcase
    end
  end

  // One phase step per cycle with go: the phase whose time has run hands over.
  always_comb begin
    cont     = (ent.phase != ow_pkg::PH_IDLE) && (ent.cnt >= phase_dur(ent.phase, cfg));
    adv      = ent;
    adv.cnt  = '0;
    fin      = 1'b0;
    fin_data = '0;
    is_write = (ent.opk == ow_pkg::K_WBYTE) || (ent.opk == ow_pkg::K_WBIT);
    total    = ((ent.opk == ow_pkg::K_WBYTE) || (ent.opk == ow_pkg::K_RBYTE)) ?
               ow_pkg::BYTE_TOTAL : ow_pkg::BIT_TOTAL;
    nb       = ent.bidx + 1'b1;
    case (ent.phase)
      ow_pkg::PH_RST_LOW:  adv.phase = ow_pkg::PH_RST_WAIT;
      ow_pkg::PH_RST_WAIT: begin
        adv.sreg  = ow_pkg::DATA_BITS'(head.line);
        adv.phase = ow_pkg::PH_RST_TAIL;
      end
      ow_pkg::PH_RST_TAIL: begin
        adv.phase = ow_pkg::PH_IDLE;
        fin       = 1'b1;
        fin_data  = ow_pkg::DATA_BITS'(ent.sreg[0]);
      end
      ow_pkg::PH_W1_LOW:   adv.phase = ow_pkg::PH_W1_REL;
      ow_pkg::PH_RD_LOW:   adv.phase = ow_pkg::PH_RD_WAIT;
      ow_pkg::PH_RD_WAIT: begin
        adv.sreg  = ent.sreg |
                    (ow_pkg::DATA_BITS'(head.line) << ent.bidx[ow_pkg::BIT_AW-1:0]);
        adv.phase = ow_pkg::PH_RD_TAIL;
      end
      ow_pkg::PH_W1_REL,
      ow_pkg::PH_W0_HOLD,
      ow_pkg::PH_RD_TAIL: begin
        // End of a slot: either the operation is complete or the next bit starts.
        adv.bidx = nb;
        if (nb >= total) begin
          adv.phase = ow_pkg::PH_IDLE;
          fin       = 1'b1;
          if (ent.opk == ow_pkg::K_RBYTE) begin
            fin_data = ent.sreg;
          end else if (ent.opk == ow_pkg::K_RBIT) begin
            fin_data = ow_pkg::DATA_BITS'(ent.sreg[0]);
          end
        end else if (is_write) begin
          adv.phase = ent.sreg[nb[ow_pkg::BIT_AW-1:0]] ? ow_pkg::PH_W1_LOW
                                                        : ow_pkg::PH_W0_HOLD;
        end else begin
          adv.phase = ow_pkg::PH_RD_LOW;
        end
      end
      default: begin
        adv.phase = ow_pkg::PH_IDLE;
        fin       = 1'b1;
      end
    endcase
    if (!cont) begin
      fin      = 1'b0;
      fin_data = '0;
    end
    nxt  = cont ? adv : ent;
    more = cont && (adv.phase != ow_pkg::PH_IDLE) &&
           (phase_dur(adv.phase, cfg) == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur.phase <= ow_pkg::PH_IDLE;
      cur.cnt   <= '0;
      cur.bidx  <= '0;
      cur.sreg  <= '0;
      cur.opk   <= ow_pkg::K_TICK;
      working   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (go) begin
        cur     <= nxt;
        working <= more;
      end
      if (pop) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res.drive_low <= (nxt.phase == ow_pkg::PH_RST_LOW) ||
                       (nxt.phase == ow_pkg::PH_W1_LOW)  ||
                       (nxt.phase == ow_pkg::PH_W0_HOLD) ||
                       (nxt.phase == ow_pkg::PH_RD_LOW);
      res.busy      <= (nxt.phase != ow_pkg::PH_IDLE);
      res.done      <= fin;
      res.data      <= fin_data;
      res.rejected  <= rej;
    end
  end

endmodule

// ===== rtl/ow_checker.sv =====
`include "one_wire_bus_master_top_defines.svh"

module ow_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic                          drive_low,
  input logic                          busy_res,
  input logic                          done_res,
  input logic [ow_pkg::DATA_BITS-1:0]  result_data,
  input logic                          rejected
);

  // A finished operation leaves the bus released and the master idle.
  `OW_ASSERT_IMPLY(a_done_idle, clk, rst, out_valid && done_res, !busy_res && !drive_low)

  // A refused command is only possible while an operation is running.
  `OW_ASSERT_IMPLY(a_reject_busy, clk, rst, out_valid && rejected, busy_res && !done_res)

  // Result data is only carried by a beat that completes an operation.
  `OW_ASSERT_IMPLY(a_data_zero, clk, rst, out_valid && !done_res, result_data == '0)

  // The bus is only pulled low in the middle of an operation.
  `OW_ASSERT_IMPLY(a_drive_busy, clk, rst, out_valid && drive_low, busy_res)

  // A held beat keeps its result.
  `OW_ASSERT_NEXT(a_hold, clk, rst, out_valid && out_stall, out_valid && $stable(result_data))

endmodule

bind one_wire_bus_master_top ow_checker u_ow_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .drive_low   (drive_low),
  .busy_res    (busy_res),
  .done_res    (done_res),
  .result_data (result_data),
  .rejected    (rejected)
);

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

// Self-checking bench for the one-wire bus master.
//
// A queue of tick, command and other beats is filled by the stimulus process. A
// falling-edge driver offers them in bursts, and a falling-edge receiver
// stalls the result channel on a shifting pattern. On every rising edge the
// monitor first checks any result beat taken there against the oldest owed
// bus state. It then runs each input beat taken there through a local copy of
// the slot sequencer and queues the bus state that the beat must produce.
// Every input beat produces exactly one result beat, so the two queues stay in
// step. Timings are only reprogrammed once everything has drained and the
// local sequencer has returned to idle.
module tb_top;
  import ow_pkg::*;

  // Cycles with no beat moving on any channel before the run is abandoned.
  // The longest stretch in a correct run is the long receiver hold below.
  localparam int IDLE_LIMIT = 4000;
  localparam int LONG_HOLD  = 150;

  typedef struct packed {
    logic [2:0]           kind;
    logic [DATA_BITS-1:0] data;
    logic                 lvl;
  } bus_beat_t;

  typedef enum logic [1:0] {
    FLOW,
    SPARSE,
    ALTERNATE,
    CHOKED
  } stall_pattern_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [2:0]           kind = K_TICK;
  logic [DATA_BITS-1:0] data = '0;
  logic                 line_level = 1'b1;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 drive_low;
  logic                 busy_res;
  logic                 done_res;
  logic [DATA_BITS-1:0] result_data;
  logic                 rejected;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IW-1:0]    cfg_index = REG_RESET_LOW;
  logic [CFG_DW-1:0]    cfg_data = '0;

  one_wire_bus_master_top dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .kind        (kind),
    .data        (data),
    .line_level  (line_level),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .drive_low   (drive_low),
    .busy_res    (busy_res),
    .done_res    (done_res),
    .result_data (result_data),
    .rejected    (rejected),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Beats waiting to be offered, and bus states owed by the block for beats it
  // has already taken.
  bus_beat_t beats_to_send [$];
  res_t      owed_states [$];

  // Local copy of the slot timings and of the sequencer state.
  logic [CFG_DW-1:0]    slot_us [8];
  phase_t               seq_phase;
  logic [CNT_W-1:0]     seq_us;
  logic [BIDX_W-1:0]    seq_bit;
  logic [DATA_BITS-1:0] seq_shift;
  logic [2:0]           seq_op;
  logic                 seq_done;
  logic [DATA_BITS-1:0] seq_value;

  int unsigned mismatch_count = 0;
  logic        in_fire = 1'b0;
  int          gap_left = 0;
  int          burst_left = 1;
  int          gap_pick;
  bus_beat_t   next_beat;
  logic        hold_req = 1'b0;
  int          hold_left = 0;
  int          stall_run = 0;
  stall_pattern_t stall_mode = FLOW;
  int          quiet_cycles = 0;

  // Length in microsecond ticks of each timed phase.
  function automatic logic [CNT_W-1:0] phase_length(phase_t p);
    case (p)
      PH_RST_LOW:  return slot_us[REG_RESET_LOW];
      PH_RST_WAIT: return slot_us[REG_PRESENCE_WAIT];
      PH_RST_TAIL: return slot_us[REG_RESET_TAIL];
      PH_W1_LOW:   return slot_us[REG_WRITE_ONE_LOW];
      PH_W1_REL:   return slot_us[REG_WRITE_SLOT];
      PH_W0_HOLD:  return slot_us[REG_WRITE_SLOT];
      PH_RD_LOW:   return slot_us[REG_READ_LOW];
      PH_RD_WAIT:  return slot_us[REG_READ_SAMPLE];
      PH_RD_TAIL:  return slot_us[REG_READ_TAIL];
      default:     return '0;
    endcase
  endfunction

  function automatic void complete_op(logic [DATA_BITS-1:0] value);
    seq_phase = PH_IDLE;
    seq_us    = '0;
    seq_done  = 1'b1;
    seq_value = value;
  endfunction

  // A write slot opens low for a one or held low for a zero; a read slot
  // always opens with the short low pulse.
  function automatic void open_slot();
    seq_us = '0;
    if (seq_op == K_WBYTE || seq_op == K_WBIT) begin
      seq_phase = seq_shift[seq_bit[2:0]] ? PH_W1_LOW : PH_W0_HOLD;
    end else begin
      seq_phase = PH_RD_LOW;
    end
  endfunction

  function automatic void close_slot();
    logic [BIDX_W-1:0] total;
    total   = (seq_op == K_WBYTE || seq_op == K_RBYTE) ? BYTE_TOTAL : BIT_TOTAL;
    seq_bit = seq_bit + 1'b1;
    if (seq_bit >= total) begin
      if (seq_op == K_RBYTE) begin
        complete_op(seq_shift);
      end else if (seq_op == K_RBIT) begin
        complete_op(DATA_BITS'(seq_shift[0]));
      end else begin
        complete_op('0);
      end
    end else begin
      open_slot();
    end
  endfunction

  function automatic void take_phase_step(logic lvl);
    seq_us = '0;
    case (seq_phase)
      PH_RST_LOW:  seq_phase = PH_RST_WAIT;
      PH_RST_WAIT: begin
        seq_shift = DATA_BITS'(lvl);
        seq_phase = PH_RST_TAIL;
      end
      PH_RST_TAIL: complete_op(DATA_BITS'(seq_shift[0]));
      PH_W1_LOW:   seq_phase = PH_W1_REL;
      PH_W1_REL, PH_W0_HOLD, PH_RD_TAIL: close_slot();
      PH_RD_LOW:   seq_phase = PH_RD_WAIT;
      PH_RD_WAIT: begin
        seq_shift[seq_bit[2:0]] = seq_shift[seq_bit[2:0]] | lvl;
        seq_phase = PH_RD_TAIL;
      end
      default:     complete_op('0);
    endcase
  endfunction

  // Phases whose time has run out end on this beat, chaining through any
  // phase of zero length that follows.
  function automatic void run_due_phases(logic lvl);
    int guard;
    guard = 0;
    while (seq_phase != PH_IDLE && !seq_done && seq_us >= phase_length(seq_phase)
           && guard < 256) begin
      take_phase_step(lvl);
      guard++;
    end
  endfunction

  // Advances the sequencer by one input beat and returns the bus state after it.
  function automatic res_t slot_step(logic [2:0] k, logic [DATA_BITS-1:0] d, logic lvl);
    res_t r;
    seq_done   = 1'b0;
    seq_value  = '0;
    r.rejected = 1'b0;
    if (k == K_TICK) begin
      if (seq_phase != PH_IDLE) begin
        if (seq_us != CNT_MAX) seq_us++;
        run_due_phases(lvl);
      end
    end else if (k <= K_RBIT) begin
      if (seq_phase != PH_IDLE) begin
        r.rejected = 1'b1;
      end else begin
        seq_op  = k;
        seq_bit = '0;
        seq_us  = '0;
        case (k)
          K_WBYTE: seq_shift = d;
          K_WBIT:  seq_shift = DATA_BITS'(d[0]);
          default: seq_shift = '0;
        endcase
        if (k == K_RESET) begin
          seq_phase = PH_RST_LOW;
        end else begin
          open_slot();
        end
        run_due_phases(lvl);
      end
    end
    r.drive_low = seq_phase == PH_RST_LOW || seq_phase == PH_W1_LOW ||
                  seq_phase == PH_W0_HOLD || seq_phase == PH_RD_LOW;
    r.busy = seq_phase != PH_IDLE;
    r.done = seq_done;
    r.data = seq_done ? seq_value : '0;
    return r;
  endfunction

  // Result beats are checked before the input beat of the same edge is added,
  // which is safe since a result is registered and leaves after its input edge.
  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      in_fire = 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (owed_states.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("%0t: result beat with nothing owed", $realtime);
        end else begin
          want = owed_states.pop_front();
          if (want.drive_low !== drive_low || want.busy !== busy_res ||
              want.done !== done_res || want.data !== result_data ||
              want.rejected !== rejected) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("%0t: expected drive_low %0b busy %0b done %0b data %02h rejected %0b",
                       $realtime, want.drive_low, want.busy, want.done, want.data,
                       want.rejected);
              $display("%0t:      got drive_low %0b busy %0b done %0b data %02h rejected %0b",
                       $realtime, drive_low, busy_res, done_res, result_data, rejected);
            end
          end
        end
      end
      in_fire = in_valid && !in_stall;
      if (in_fire) owed_states.push_back(slot_step(kind, data, line_level));
    end
  end

  // The sender offers beats in bursts of random length. Some gaps are empty so
  // that long back-to-back runs occur as well.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (beats_to_send.size() != 0) begin
        next_beat = beats_to_send.pop_front();
        kind       <= next_beat.kind;
        data       <= next_beat.data;
        line_level <= next_beat.lvl;
        in_valid   <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 48);
          gap_pick   = $urandom_range(0, 9);
          gap_left   = (gap_pick < 4) ? 0 :
                       (gap_pick < 8) ? $urandom_range(1, 3) : $urandom_range(4, 20);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // The receiver switches between stall patterns after runs of random length. A
  // hold request from the stimulus process makes it refuse results for a long
  // stretch, so that the block backs up and stalls its input.
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (hold_req) begin
        hold_left = LONG_HOLD;
        hold_req  = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (stall_run == 0) begin
          stall_mode = stall_pattern_t'($urandom_range(0, 3));
          stall_run  = $urandom_range(4, 60);
        end
        stall_run--;
        case (stall_mode)
          FLOW:      out_stall <= 1'b0;
          SPARSE:    out_stall <= ($urandom_range(0, 2) == 0);
          ALTERNATE: out_stall <= stall_run[0];
          default:   out_stall <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("FAIL one_wire_bus_master_top");
      $finish;
    end
  end

  function automatic void push_item(logic [2:0] k, logic [DATA_BITS-1:0] d, logic lvl);
    beats_to_send.push_back('{kind: k, data: d, lvl: lvl});
  endfunction

  // Returns once every queued beat has been taken and every owed result has
  // come back. Sampling just after the rising edge keeps this clear of the
  // driver and the monitor.
  task automatic drain();
    @(posedge clk);
    #1;
    while (beats_to_send.size() != 0 || in_valid || owed_states.size() != 0) begin
      @(posedge clk);
      #1;
    end
  endtask

  // Brings the sequencer back to idle with extra ticks, then writes all eight
  // timing registers back to back.
  task automatic program_timings(input cfg_t c);
    logic [CFG_DW-1:0] vals [8];
    int i;
    drain();
    while (seq_phase != PH_IDLE) begin
      repeat (64) push_item(K_TICK, DATA_BITS'($urandom), 1'($urandom));
      drain();
    end
    vals[REG_RESET_LOW]     = CFG_DW'(c.reset_low_us);
    vals[REG_PRESENCE_WAIT] = CFG_DW'(c.presence_wait_us);
    vals[REG_RESET_TAIL]    = CFG_DW'(c.reset_tail_us);
    vals[REG_WRITE_ONE_LOW] = CFG_DW'(c.write_one_low_us);
    vals[REG_WRITE_SLOT]    = CFG_DW'(c.write_slot_us);
    vals[REG_READ_LOW]      = CFG_DW'(c.read_low_us);
    vals[REG_READ_SAMPLE]   = CFG_DW'(c.read_sample_us);
    vals[REG_READ_TAIL]     = CFG_DW'(c.read_tail_us);
    for (i = 0; i < 8; i++) begin
      @(negedge clk);
      cfg_valid <= 1'b1;
      cfg_index <= CFG_IW'(i);
      cfg_data  <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      slot_us[i] = vals[i];
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly complete operations: a command followed by about the number of
  // ticks it needs under the current timings. Some are cut short so that the
  // next command is turned away, and stray commands and unknown kinds are
  // sprinkled among the ticks.
  task automatic random_traffic(input int budget, input bit bits_only);
    int sent;
    int ticks;
    int pick;
    int j;
    logic [2:0] op;
    logic [DATA_BITS-1:0] val;
    sent = 0;
    while (sent < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        push_item(3'($urandom_range(6, 7)), DATA_BITS'($urandom), 1'($urandom));
        sent++;
      end else if (pick < 8) begin
        push_item(K_TICK, DATA_BITS'($urandom), 1'($urandom));
        sent++;
      end else begin
        if (bits_only) begin
          case ($urandom_range(0, 2))
            0:       op = K_RESET;
            1:       op = K_WBIT;
            default: op = K_RBIT;
          endcase
        end else begin
          op = 3'($urandom_range(K_RESET, K_RBIT));
        end
        val = DATA_BITS'($urandom);
        case (op)
          K_RESET: ticks = slot_us[REG_RESET_LOW] + slot_us[REG_PRESENCE_WAIT] +
                           slot_us[REG_RESET_TAIL];
          K_RBYTE: ticks = DATA_BITS * (slot_us[REG_READ_LOW] + slot_us[REG_READ_SAMPLE] +
                           slot_us[REG_READ_TAIL]);
          K_RBIT:  ticks = slot_us[REG_READ_LOW] + slot_us[REG_READ_SAMPLE] +
                           slot_us[REG_READ_TAIL];
          default: begin
            ticks = 0;
            for (j = 0; j < ((op == K_WBYTE) ? DATA_BITS : 1); j++) begin
              ticks += slot_us[REG_WRITE_SLOT] + (val[j] ? slot_us[REG_WRITE_ONE_LOW] : 0);
            end
          end
        endcase
        if ($urandom_range(0, 99) < 12) begin
          ticks = ticks / 2;
        end else begin
          ticks += $urandom_range(0, 3);
        end
        push_item(op, val, 1'($urandom));
        sent++;
        for (j = 0; j < ticks; j++) begin
          pick = $urandom_range(0, 99);
          if (pick < 3) begin
            push_item(3'($urandom_range(K_RESET, K_RBIT)), DATA_BITS'($urandom), 1'($urandom));
            sent++;
          end else if (pick < 5) begin
            push_item(3'($urandom_range(6, 7)), DATA_BITS'($urandom), 1'($urandom));
            sent++;
          end
          push_item(K_TICK, DATA_BITS'($urandom), 1'($urandom));
          sent++;
        end
        // Now and then the sender waits for every owed result before going on.
        if ($urandom_range(0, 99) == 0) drain();
      end
    end
  endtask

  initial begin
    cfg_t setting;
    int   n;
    slot_us[REG_RESET_LOW]     = 10'd490;
    slot_us[REG_PRESENCE_WAIT] = 10'd40;
    slot_us[REG_RESET_TAIL]    = 10'd450;
    slot_us[REG_WRITE_ONE_LOW] = 10'd1;
    slot_us[REG_WRITE_SLOT]    = 10'd100;
    slot_us[REG_READ_LOW]      = 10'd1;
    slot_us[REG_READ_SAMPLE]   = 10'd15;
    slot_us[REG_READ_TAIL]     = 10'd105;
    seq_phase = PH_IDLE;
    seq_us    = '0;
    seq_bit   = '0;
    seq_shift = '0;
    seq_op    = K_TICK;
    seq_done  = 1'b0;
    seq_value = '0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // With every timing at zero each command completes on its own beat, and a
    // reset samples the presence level of that same beat.
    program_timings(cfg_t'('0));
    push_item(K_TICK, 8'hFF, 1'b1);
    push_item(K_RESET, 8'h00, 1'b0);
    push_item(K_RESET, 8'hFF, 1'b1);
    push_item(K_WBYTE, 8'h00, 1'b0);
    push_item(K_WBYTE, 8'hFF, 1'b1);
    push_item(K_WBIT, 8'hFE, 1'b1);
    push_item(K_WBIT, 8'h01, 1'b0);
    push_item(K_RBYTE, 8'h00, 1'b1);
    push_item(K_RBYTE, 8'hFF, 1'b0);
    push_item(K_RBIT, 8'hA5, 1'b1);
    push_item(K_RBIT, 8'h5A, 1'b0);
    push_item(3'd6, 8'h5A, 1'b0);
    push_item(3'd7, 8'hA5, 1'b1);

    // One-tick phases: commands and unknown kinds arriving mid-reset are turned
    // away or ignored and do not count as time passing.
    program_timings(cfg_t'{10'd1, 8'd1, 10'd1, 4'd1, 8'd1, 4'd1, 6'd1, 8'd1});
    push_item(K_RESET, 8'h00, 1'b1);
    push_item(K_WBYTE, 8'hFF, 1'b1);
    push_item(K_TICK, 8'h00, 1'b1);
    push_item(K_RBIT, 8'h00, 1'b1);
    push_item(K_TICK, 8'hFF, 1'b0);
    push_item(3'd7, 8'hFF, 1'b1);
    push_item(K_TICK, 8'h00, 1'b1);
    push_item(K_TICK, 8'h00, 1'b0);

    program_timings(cfg_t'('0));
    random_traffic(220, 1'b0);

    setting.reset_low_us     = 10'($urandom_range(0, 3));
    setting.presence_wait_us = 8'($urandom_range(0, 3));
    setting.reset_tail_us    = 10'($urandom_range(0, 3));
    setting.write_one_low_us = 4'($urandom_range(0, 3));
    setting.write_slot_us    = 8'($urandom_range(0, 3));
    setting.read_low_us      = 4'($urandom_range(0, 3));
    setting.read_sample_us   = 6'($urandom_range(0, 3));
    setting.read_tail_us     = 8'($urandom_range(0, 3));
    program_timings(setting);
    random_traffic(320, 1'b0);

    // Wider timings, and the receiver holds off for a long stretch while the
    // sender keeps offering beats.
    setting.reset_low_us     = 10'($urandom_range(0, 20));
    setting.presence_wait_us = 8'($urandom_range(0, 10));
    setting.reset_tail_us    = 10'($urandom_range(0, 20));
    setting.write_one_low_us = 4'($urandom_range(0, 15));
    setting.write_slot_us    = 8'($urandom_range(0, 12));
    setting.read_low_us      = 4'($urandom_range(0, 15));
    setting.read_sample_us   = 6'($urandom_range(0, 10));
    setting.read_tail_us     = 8'($urandom_range(0, 12));
    program_timings(setting);
    hold_req = 1'b1;
    random_traffic(380, 1'b0);

    // Every timing at its largest value: one long write slot of a one, with a
    // command turned away part way through, then one long read slot.
    program_timings(cfg_t'{10'h3FF, 8'hFF, 10'h3FF, 4'hF, 8'hFF, 4'hF, 6'h3F, 8'hFF});
    push_item(K_WBIT, 8'h01, 1'b1);
    for (n = 0; n < 272; n++) begin
      if (n == 100) push_item(K_RESET, 8'h00, 1'b0);
      push_item(K_TICK, DATA_BITS'($urandom), 1'($urandom));
    end
    push_item(K_RBIT, 8'h00, 1'b1);
    for (n = 0; n < 335; n++) begin
      push_item(K_TICK, DATA_BITS'($urandom), 1'($urandom));
    end

    setting.reset_low_us     = 10'($urandom_range(0, 4));
    setting.presence_wait_us = 8'($urandom_range(0, 4));
    setting.reset_tail_us    = 10'($urandom_range(0, 4));
    setting.write_one_low_us = 4'($urandom_range(0, 4));
    setting.write_slot_us    = 8'($urandom_range(0, 4));
    setting.read_low_us      = 4'($urandom_range(0, 4));
    setting.read_sample_us   = 6'($urandom_range(0, 4));
    setting.read_tail_us     = 8'($urandom_range(0, 4));
    program_timings(setting);
    random_traffic(220, 1'b0);

    drain();
    // A short quiet spell catches any result beat that nothing asked for.
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS one_wire_bus_master_top");
    end else begin
      $display("FAIL one_wire_bus_master_top");
    end
    $finish;
  end

endmodule

// ===== one_wire_bus_master_top.f =====
+incdir+rtl
rtl/ow_pkg.sv
rtl/ow_cfg.sv
rtl/ow_front.sv
rtl/ow_queue.sv
rtl/ow_back.sv
rtl/one_wire_bus_master_top.sv
rtl/ow_checker.sv
bench/tb_top.sv
